// ===== rtl/nv12rgb_pkg.sv =====
// Shared types, constants and register codes of the NV12 to RGB converter.
package nv12rgb_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

    // Conversion arithmetic runs in this signed width.
    localparam int ARITH_W = 20;

    localparam logic signed [ARITH_W-1:0] K_298   = 20'sd298;
    localparam logic signed [ARITH_W-1:0] K_409   = 20'sd409;
    localparam logic signed [ARITH_W-1:0] K_100   = 20'sd100;
    localparam logic signed [ARITH_W-1:0] K_208   = 20'sd208;
    localparam logic signed [ARITH_W-1:0] K_516   = 20'sd516;
    localparam logic signed [ARITH_W-1:0] K_359   = 20'sd359;
    localparam logic signed [ARITH_W-1:0] K_88    = 20'sd88;
    localparam logic signed [ARITH_W-1:0] K_183   = 20'sd183;
    localparam logic signed [ARITH_W-1:0] K_454   = 20'sd454;
    localparam logic signed [ARITH_W-1:0] K_ROUND = 20'sd128;
    localparam logic signed [ARITH_W-1:0] K_MAX8  = 20'sd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_SWAP_CHROMA  = 2'd2,
        CFG_FULL_RANGE   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } pix_flags_t;

    typedef struct packed {
        logic swap_chroma;
        logic full_range;
    } cvt_cfg_t;

endpackage

// ===== rtl/nv12rgb_color.sv =====
// BT.601 YUV to RGB conversion pipeline with clamping and an output register.
module nv12rgb_color
    import nv12rgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cvt_cfg_t   cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_luma,
    input  logic [15:0] in_pair,
    input  pix_flags_t in_flags,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output pix_flags_t out_flags
);

    function automatic logic [7:0] clamp8(input logic signed [ARITH_W-1:0] v);
        logic [7:0] res;
        if (v < 0)
        begin
            res = 8'd0;
        end
        else if (v > K_MAX8)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    logic en_b;
    logic en_c;

    // Product stage registers.
    logic                      vb_reg;
    logic [7:0]                y_b_reg;
    pix_flags_t                flags_b_reg;
    logic signed [ARITH_W-1:0] c298_reg, e409_reg, d100_reg, e208_reg, d516_reg;
    logic signed [ARITH_W-1:0] e359_reg, d88_reg, e183_reg, d454_reg;

    logic signed [ARITH_W-1:0] c298_next, e409_next, d100_next, e208_next, d516_next;
    logic signed [ARITH_W-1:0] e359_next, d88_next, e183_next, d454_next;

    // Output registers.
    logic       ov_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    pix_flags_t flags_o_reg;
    logic [7:0] red_next, green_next, blue_next;

    logic [7:0]                u_byte, v_byte;
    logic signed [8:0]         d_s, e_s;
    logic signed [9:0]         ym16;
    logic signed [ARITH_W-1:0] d_x, e_x, c_x;

    assign en_c     = !ov_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign in_ready = en_b;

    always_comb
    begin
        u_byte = cfg.swap_chroma ? in_pair[7:0]  : in_pair[15:8];
        v_byte = cfg.swap_chroma ? in_pair[15:8] : in_pair[7:0];
        d_s    = $signed({1'b0, u_byte}) - 9'sd128;
        e_s    = $signed({1'b0, v_byte}) - 9'sd128;
        ym16   = $signed({2'b00, in_luma}) - 10'sd16;
        d_x    = ARITH_W'(d_s);
        e_x    = ARITH_W'(e_s);
        c_x    = ARITH_W'(ym16);
        c298_next = c_x * K_298;
        e409_next = e_x * K_409;
        d100_next = d_x * K_100;
        e208_next = e_x * K_208;
        d516_next = d_x * K_516;
        e359_next = e_x * K_359;
        d88_next  = d_x * K_88;
        e183_next = e_x * K_183;
        d454_next = d_x * K_454;
    end

    always_comb
    begin
        logic signed [ARITH_W-1:0] y_x;
        logic signed [ARITH_W-1:0] r_v, g_v, b_v;
        y_x = ARITH_W'($signed({1'b0, y_b_reg}));
        if (cfg.full_range)
        begin
            r_v = y_x + ((e359_reg + K_ROUND) >>> 8);
            g_v = y_x - ((d88_reg + e183_reg + K_ROUND) >>> 8);
            b_v = y_x + ((d454_reg + K_ROUND) >>> 8);
        end
        else
        begin
            r_v = (c298_reg + e409_reg + K_ROUND) >>> 8;
            g_v = (c298_reg - d100_reg - e208_reg + K_ROUND) >>> 8;
            b_v = (c298_reg + d516_reg + K_ROUND) >>> 8;
        end
        red_next   = clamp8(r_v);
        green_next = clamp8(g_v);
        blue_next  = clamp8(b_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en_b)
            begin
                vb_reg <= in_valid;
            end
            if (en_c)
            begin
                ov_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            y_b_reg     <= in_luma;
            flags_b_reg <= in_flags;
            c298_reg    <= c298_next;
            e409_reg    <= e409_next;
            d100_reg    <= d100_next;
            e208_reg    <= e208_next;
            d516_reg    <= d516_next;
            e359_reg    <= e359_next;
            d88_reg     <= d88_next;
            e183_reg    <= e183_next;
            d454_reg    <= d454_next;
        end
        if (en_c)
        begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            flags_o_reg <= flags_b_reg;
        end
    end

    assign out_valid = ov_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_flags = flags_o_reg;

endmodule

// ===== rtl/nv12_to_rgb_converter_top.sv =====
// Top level of the streaming NV12/NV21 to RGB888 converter with its chroma line buffer.
//
// The block takes one pixel per clock while the output side is ready and returns one
// RGB item per pixel. Three pipeline registers (the line-buffer read stage, the
// constant-product stage and the output register) lie between input and output and
// can hold up to three items, so input is accepted while a finished item
// waits. The chroma line buffer is a single-port memory of (MAX_WIDTH+1)/2 pairs:
// even rows write one entry per even column, odd rows read one entry per pixel,
// which sets the one-pixel-per-clock rate. The buffer has no reset or clearing pass;
// it is written by each even row before the following odd row reads it.
module nv12_to_rgb_converter_top
    import nv12rgb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Pixel input. tdata: luma[7:0], chroma_first[15:8], chroma_second[23:16].
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,
    // RGB output. tdata: red[7:0], green[15:8], blue[23:16].
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,
    // tlast: row_end.
    output logic                 m_axis_tlast,
    // tuser: frame_end.
    output logic                 m_axis_tuser
);

    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LINE_AW    = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;
    localparam int SZW_A      = $clog2(MAX_WIDTH + 1);
    localparam int SZH_A      = $clog2(MAX_HEIGHT + 1);
    localparam int SIZE_W     = (SZW_A > CFG_W) ? ((SZH_A > SZW_A) ? SZH_A : SZW_A)
                                                : ((SZH_A > CFG_W) ? SZH_A : CFG_W);

    // Configuration registers.
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             swap_reg;
    logic             full_reg;

    // Raster position and held chroma pair.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [15:0]      held_reg, held_next;

    // Read stage.
    logic             va_reg;
    logic [7:0]       y_a_reg;
    logic [15:0]      pair_a_reg;
    logic             use_line_a_reg;
    pix_flags_t       flags_a_reg;
    pix_flags_t       flags_next;
    logic [15:0]      pair_next;

    logic [15:0]      line_mem [LINE_DEPTH];
    logic [15:0]      rd_data_reg;
    logic [LINE_AW-1:0] line_addr;
    logic             wr_en;
    logic             rd_en;

    logic [SIZE_W-1:0] w_eff, h_eff;
    logic             last_col, last_row;
    logic             en_a;
    logic             accept;
    logic             even_row, even_col;
    logic [15:0]      in_pair;

    logic             cvt_in_ready;
    cvt_cfg_t         cvt_cfg;
    pix_flags_t       out_flags;
    logic [7:0]       out_red, out_green, out_blue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            swap_reg   <= 1'b0;
            full_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                CFG_SWAP_CHROMA:  swap_reg   <= cfg_data[0];
                CFG_FULL_RANGE:   full_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Zero sizes act as one, oversize values saturate at the maximum.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = SIZE_W'(1);
        end
        else if (SIZE_W'(width_reg) > SIZE_W'(MAX_WIDTH))
        begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = SIZE_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = SIZE_W'(1);
        end
        else if (SIZE_W'(height_reg) > SIZE_W'(MAX_HEIGHT))
        begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = SIZE_W'(height_reg);
        end
    end

    assign en_a          = !va_reg || cvt_in_ready;
    assign s_axis_tready = en_a;
    assign accept        = s_axis_tvalid && en_a;

    assign even_row  = !row_reg[0];
    assign even_col  = !col_reg[0];
    // The stored pair keeps the first chroma byte in its upper half.
    assign in_pair   = {s_axis_tdata[15:8], s_axis_tdata[23:16]};
    assign line_addr = LINE_AW'(col_reg >> 1);
    assign wr_en     = accept && even_row && even_col;
    assign rd_en     = accept && !even_row;

    assign last_col = (SIZE_W'(col_reg) + SIZE_W'(1)) >= w_eff;
    assign last_row = (SIZE_W'(row_reg) + SIZE_W'(1)) >= h_eff;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (wr_en)
            begin
                held_next = in_pair;
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : ROW_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
        pair_next            = held_next;
        flags_next.row_end   = last_col;
        flags_next.frame_end = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
            va_reg   <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
            if (en_a)
            begin
                va_reg <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            y_a_reg        <= s_axis_tdata[7:0];
            pair_a_reg     <= pair_next;
            use_line_a_reg <= !even_row;
            flags_a_reg    <= flags_next;
        end
    end

    // Chroma line buffer: even rows write, odd rows read, never both at once.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[line_addr] <= in_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem[line_addr];
        end
    end

    assign cvt_cfg.swap_chroma = swap_reg;
    assign cvt_cfg.full_range  = full_reg;

    nv12rgb_color u_color
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cvt_cfg),
        .in_valid  (va_reg),
        .in_ready  (cvt_in_ready),
        .in_luma   (y_a_reg),
        .in_pair   (use_line_a_reg ? rd_data_reg : pair_a_reg),
        .in_flags  (flags_a_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_flags (out_flags)
    );

    assign m_axis_tdata = {out_blue, out_green, out_red};
    assign m_axis_tlast = out_flags.row_end;
    assign m_axis_tuser = out_flags.frame_end;

`ifndef SYNTHESIS
    // A frame end is always also a row end.
    a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame_end without row_end");

    // The last pixel of a row sends the column count back to zero.
    a_col_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_col |=> col_reg == '0)
        else $error("column count did not wrap at row end");

    // Input stalls only while the read stage holds an item.
    a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> va_reg)
        else $error("input stalled with empty read stage");

    // The single memory port never sees a read and a write together.
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("line buffer read and write in one cycle");
`endif

endmodule

// ===== tb/nv12_rgb_checker.sv =====
`timescale 1ns / 100ps
// Checker that follows the converter's channels, predicts every RGB item and compares it.
module nv12_rgb_checker
    import nv12rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // tdata: luma[7:0], chroma_first[15:8], chroma_second[23:16].
    input  logic [23:0]          s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16].
    input  logic [23:0]          m_axis_tdata,
    // tlast: row_end.
    input  logic                 m_axis_tlast,
    // tuser: frame_end.
    input  logic                 m_axis_tuser,
    output int                   rgb_due_count,
    output int                   error_count
);

    localparam int LINE_DEPTH = (DEF_MAX_WIDTH + 1) / 2;
    localparam int PRINT_CAP  = 50;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } rgb_item_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             swap_reg;
    logic             full_reg;
    logic [15:0]      chroma_pairs [LINE_DEPTH];
    logic [15:0]      held_pair;
    int               col_pos;
    int               row_pos;
    int               results_seen;
    rgb_item_t        rgb_due_q [$];
    rgb_item_t        oldest_due;

    function automatic int eff_size(input logic [CFG_W-1:0] value, input int limit);
        if (value == 0)
            return 1;
        return (int'(value) > limit) ? limit : int'(value);
    endfunction

    function automatic logic [7:0] sat8(input int value);
        if (value < 0)
            return 8'd0;
        if (value > 255)
            return 8'd255;
        return value[7:0];
    endfunction

    // Converts one pixel and advances the raster position; also updates the chroma store.
    function automatic rgb_item_t convert_pixel(input logic [23:0] pixel);
        int          w_eff;
        int          h_eff;
        int          y;
        int          d;
        int          e;
        int          c;
        int          r;
        int          g;
        int          b;
        logic [15:0] pair;
        logic [7:0]  u_byte;
        logic [7:0]  v_byte;
        logic        last_col;
        logic        last_row;
        rgb_item_t   res;

        w_eff = eff_size(width_reg, DEF_MAX_WIDTH);
        h_eff = eff_size(height_reg, DEF_MAX_HEIGHT);
        y = int'(pixel[7:0]);

        // Even rows take a new pair on even columns; odd rows read what the even row stored.
        if (row_pos[0] == 1'b0)
        begin
            if (col_pos[0] == 1'b0)
            begin
                held_pair = {pixel[15:8], pixel[23:16]};
                chroma_pairs[col_pos >> 1] = held_pair;
            end
            pair = held_pair;
        end
        else
        begin
            pair = chroma_pairs[col_pos >> 1];
        end

        u_byte = swap_reg ? pair[7:0] : pair[15:8];
        v_byte = swap_reg ? pair[15:8] : pair[7:0];
        d = int'(u_byte) - 128;
        e = int'(v_byte) - 128;

        if (full_reg)
        begin
            r = y + ((359 * e + 128) >>> 8);
            g = y - ((88 * d + 183 * e + 128) >>> 8);
            b = y + ((454 * d + 128) >>> 8);
        end
        else
        begin
            c = 298 * (y - 16);
            r = (c + 409 * e + 128) >>> 8;
            g = (c - 100 * d - 208 * e + 128) >>> 8;
            b = (c + 516 * d + 128) >>> 8;
        end

        // A counter at or past a shrunk size still closes its row or frame.
        last_col = (col_pos + 1 >= w_eff);
        last_row = (row_pos + 1 >= h_eff);

        res.red       = sat8(r);
        res.green     = sat8(g);
        res.blue      = sat8(b);
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return res;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_error($sformatf("item %0d: %s is %0d, expected %0d",
                                   results_seen, field, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     = RST_FRAME_WIDTH;
            height_reg    = RST_FRAME_HEIGHT;
            swap_reg      = 1'b0;
            full_reg      = 1'b0;
            held_pair     = '0;
            col_pos       = 0;
            row_pos       = 0;
            results_seen  = 0;
            error_count   = 0;
            rgb_due_q.delete();
            rgb_due_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_FRAME_WIDTH:  width_reg  = cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    CFG_SWAP_CHROMA:  swap_reg   = cfg_data[0];
                    CFG_FULL_RANGE:   full_reg   = cfg_data[0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                rgb_due_q.push_back(convert_pixel(s_axis_tdata));

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rgb_due_q.size() == 0)
                begin
                    report_error($sformatf("item %0d arrived with nothing expected",
                                           results_seen));
                end
                else
                begin
                    oldest_due = rgb_due_q.pop_front();
                    check_field("red", m_axis_tdata[7:0], oldest_due.red);
                    check_field("green", m_axis_tdata[15:8], oldest_due.green);
                    check_field("blue", m_axis_tdata[23:16], oldest_due.blue);
                    check_field("row_end", m_axis_tlast, oldest_due.row_end);
                    check_field("frame_end", m_axis_tuser, oldest_due.frame_end);
                end
                results_seen++;
            end

            rgb_due_count <= rgb_due_q.size();
        end
    end

endmodule

// ===== tb/nv12_to_rgb_converter_top_test.sv =====
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, pixel and register stimulus, and verdict.
module nv12_to_rgb_converter_top_test;
    import nv12rgb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int CALM_AFTER     = 850;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;

    int rgb_due_count;
    int error_count;
    int stall_cycles;
    bit bursty = 1'b1;

    nv12_to_rgb_converter_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    nv12_rgb_checker rgb_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .rgb_due_count (rgb_due_count),
        .error_count   (error_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiving side stalls in random bursts while bursty is set.
    always
    begin
        @(posedge clk);
        if (bursty && $urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int frame_pixels(input int w, input int h);
        return ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input int w, input int h, input bit swap, input bit full);
        write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        write_reg(CFG_SWAP_CHROMA, CFG_W'(swap));
        write_reg(CFG_FULL_RANGE, CFG_W'(full));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_px(input logic [7:0] luma, input logic [7:0] first,
                           input logic [7:0] second);
        if (bursty && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {second, first, luma};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_px(pick_byte(), pick_byte(), pick_byte());
    endtask

    // Holds the pixel stream until every predicted item has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (rgb_due_count != 0);
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        int pause_at;
        int random_items;
        int phase;
        bit swap;
        bit full;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes, then shrink to 1x1 so the pixel past the new width ends the frame.
        send_px(8'h00, 8'h00, 8'h00);
        send_px(8'hFF, 8'hFF, 8'hFF);
        send_px(8'h10, 8'h80, 8'h80);
        drain_results();
        configure(1, 1, 1'b0, 1'b0);
        send_px(8'hEB, 8'hF0, 8'h10);

        // Zero sizes act as one pixel per frame.
        drain_results();
        configure(0, 0, 1'b0, 1'b1);
        send_px(8'hFF, 8'h00, 8'hFF);
        send_px(8'h00, 8'hFF, 8'h00);

        // Odd width and height with swapped chroma.
        drain_results();
        configure(3, 3, 1'b1, 1'b0);
        send_random(9);

        // Oversize sizes, then shrink both while the column is past the new width.
        drain_results();
        configure(8191, 8191, 1'b0, 1'b1);
        send_random(4);
        drain_results();
        configure(2, 2, 1'b1, 1'b1);
        send_random(3);

        // Height shrunk below the current row.
        drain_results();
        configure(1, 4, 1'b0, 1'b0);
        send_random(3);
        drain_results();
        configure(1, 2, 1'b0, 1'b0);
        send_random(1);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            drain_results();
            bursty = (random_items < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 11))
                0:       w = 0;
                1:       w = $urandom_range(60, 200);
                default: w = $urandom_range(1, 24);
            endcase
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (w > 24) ? 2 : 6);
            swap = 1'($urandom_range(0, 1));
            full = 1'($urandom_range(0, 1));
            configure(w, h, swap, full);
            n = frame_pixels(w, h) * $urandom_range(1, 2);
            // The last frame of the run may end early to keep the item count on target.
            if (n > RANDOM_ITEMS - random_items)
                n = RANDOM_ITEMS - random_items;

            if ($urandom_range(0, 5) == 0)
            begin
                // Cut the frame short: a 1x1 size closes it on the next pixel.
                n = $urandom_range(1, n);
                send_random(n);
                drain_results();
                configure(1, 1, swap, full);
                send_random(1);
                n = n + 1;
            end
            else
            begin
                pause_at = (phase == 1) ? n / 2 : -1;
                for (int i = 0; i < n; i++)
                begin
                    if (i == pause_at)
                        drain_results();
                    send_px(pick_byte(), pick_byte(), pick_byte());
                end
            end
            random_items += n;
            phase++;
        end

        bursty = 1'b0;
        drain_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
